### design/waypoint_coverage_table_core_macros.svh
// Assertion macros for the waypoint coverage table RTL.
// Expects aclk and aresetn in the scope of every use.
`ifndef WAYPOINT_COVERAGE_TABLE_CORE_MACROS_SVH
`define WAYPOINT_COVERAGE_TABLE_CORE_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define WCT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define WCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/wct_pkg.sv
// Shared types and constants for the waypoint coverage table.
// No dependencies.
package wct_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int COORD_W      = 24;
    localparam int COUNT_W      = 7;
    localparam int POINT_W      = 2 * COORD_W;
    localparam int S_TDATA_W    = 48;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 56;
    localparam int M_TUSER_W    = 3;
    localparam logic [COORD_W-1:0] RADIUS_RESET = 24'd2560;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COVER  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    append;
        logic    clear;
        logic    scan_start;
        logic    scan_en;
        logic    commit;
        logic    emit_start;
        logic    emit_read;
        logic    post_resp;
        logic    post_point;
        status_t resp_status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic scan_done;
        logic gat_zero;
        logic emit_last;
        logic out_free;
    } dp_stat_t;

endpackage

### design/wct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wct_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/wct_ctrl.sv
// Sequencer for the waypoint coverage table: drives datapath commands.
// Depends on wct_pkg.
module wct_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  wct_pkg::dp_stat_t  stat,
    output wct_pkg::ctrl_cmd_t cmd
);
    import wct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    state_t  state_reg, state_next;
    status_t resp_status_reg, resp_status_next;

    always_comb begin
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        cmd              = '0;
        cmd.resp_status  = resp_status_reg;
        s_tready         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (stat.op)
                    OP_ADD: begin
                        if (stat.full) begin
                            resp_status_next = ST_FULL;
                        end else begin
                            cmd.append       = 1'b1;
                            resp_status_next = ST_DONE;
                        end
                        state_next = S_RESP;
                    end
                    OP_CLEAR: begin
                        cmd.clear        = 1'b1;
                        resp_status_next = ST_DONE;
                        state_next       = S_RESP;
                    end
                    default: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done) begin
                    cmd.commit = 1'b1;
                    if (stat.op == OP_COVER && !stat.gat_zero) begin
                        cmd.emit_start = 1'b1;
                        state_next     = S_EMIT_RD;
                    end else begin
                        resp_status_next = stat.gat_zero ? ST_NOMATCH : ST_DONE;
                        state_next       = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.post_resp = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (stat.out_free) begin
                    cmd.post_point = 1'b1;
                    state_next     = stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            resp_status_reg <= ST_DONE;
        end else begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
        end
    end

endmodule

### design/wct_datapath.sv
// Datapath of the waypoint coverage table: point store, scan and compaction
// pipeline, gather buffer and output register. Depends on wct_pkg, wct_ram and the macros header.
`include "waypoint_coverage_table_core_macros.svh"

module wct_datapath #(
    parameter int CAPACITY = wct_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wct_pkg::COORD_W-1:0]     cfg_wr_data,
    input  logic [wct_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [wct_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wct_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [wct_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,
    input  wct_pkg::ctrl_cmd_t              cmd,
    output wct_pkg::dp_stat_t               stat
);
    import wct_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SQ_W  = 2 * COORD_W + 1;

    // configuration and request registers
    logic [COORD_W-1:0]   radius_reg;
    logic [2*COORD_W-1:0] rsq_reg;
    op_t                  op_reg;
    logic [COORD_W-1:0]   px_reg, py_reg;

    logic [CNT_W-1:0] fill_reg, rd_idx_reg, wr_idx_reg, gat_cnt_reg, emit_idx_reg;

    // scan pipeline
    logic             v1_reg, v2_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic             eq_reg;
    logic [POINT_W-1:0] d2_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_has_reg, out_last_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [POINT_W-1:0] tbl_rdata, gat_rdata, tbl_wdata;
    logic [IDX_W-1:0]   tbl_waddr;
    logic               tbl_we, tbl_re, gat_we;

    logic signed [COORD_W:0]   dx, dy;
    logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
    logic [SQ_W:0]             dist_sum;
    logic                      in_cover, hit, out_free;

    assign tbl_re = cmd.scan_en && (rd_idx_reg != fill_reg);

    // stage 1: differences squared straight off the RAM read data
    assign dx    = $signed({tbl_rdata[COORD_W-1], tbl_rdata[COORD_W-1:0]})
                 - $signed({px_reg[COORD_W-1], px_reg});
    assign dy    = $signed({tbl_rdata[POINT_W-1], tbl_rdata[POINT_W-1:COORD_W]})
                 - $signed({py_reg[COORD_W-1], py_reg});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    // stage 2: sum, compare, then route the entry to the table or the gather buffer
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign in_cover = dist_sum < {2'b00, rsq_reg};
    assign hit      = (op_reg == OP_REMOVE) ? eq_reg : in_cover;
    assign gat_we   = v2_reg && hit;

    always_comb begin
        if (cmd.append) begin
            tbl_we    = 1'b1;
            tbl_waddr = fill_reg[IDX_W-1:0];
            tbl_wdata = {py_reg, px_reg};
        end else begin
            tbl_we    = v2_reg && !hit;
            tbl_waddr = wr_idx_reg[IDX_W-1:0];
            tbl_wdata = d2_reg;
        end
    end

    wct_ram #(.WIDTH(POINT_W), .DEPTH(CAPACITY)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (tbl_rdata)
    );

    wct_ram #(.WIDTH(POINT_W), .DEPTH(CAPACITY)) u_gather (
        .aclk  (aclk),
        .we    (gat_we),
        .waddr (gat_cnt_reg[IDX_W-1:0]),
        .wdata (d2_reg),
        .re    (cmd.emit_read),
        .raddr (emit_idx_reg[IDX_W-1:0]),
        .rdata (gat_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= RADIUS_RESET;
            fill_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_ADD;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            gat_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                op_reg <= op_t'(s_tuser[1:0]);
            end

            if (cmd.append) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (cmd.clear) begin
                fill_reg <= '0;
            end else if (cmd.commit) begin
                fill_reg <= wr_idx_reg;
            end

            v1_reg <= tbl_re;
            v2_reg <= v1_reg;

            if (cmd.scan_start) begin
                rd_idx_reg  <= '0;
                wr_idx_reg  <= '0;
                gat_cnt_reg <= '0;
            end else begin
                if (tbl_re) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (gat_we) begin
                    gat_cnt_reg <= gat_cnt_reg + CNT_W'(1);
                end
                if (v2_reg && !hit) begin
                    wr_idx_reg <= wr_idx_reg + CNT_W'(1);
                end
            end

            if (cmd.emit_start) begin
                emit_idx_reg <= '0;
            end else if (cmd.emit_read) begin
                emit_idx_reg <= emit_idx_reg + CNT_W'(1);
            end

            if (cmd.post_resp || cmd.post_point) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg  <= s_tdata[COORD_W-1:0];
            py_reg  <= s_tdata[POINT_W-1:COORD_W];
            rsq_reg <= radius_reg * radius_reg;
        end
        sqx_reg <= dx_sq[SQ_W-1:0];
        sqy_reg <= dy_sq[SQ_W-1:0];
        eq_reg  <= (tbl_rdata == {py_reg, px_reg});
        d2_reg  <= tbl_rdata;

        if (cmd.post_resp) begin
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_has_reg    <= 1'b0;
            out_status_reg <= cmd.resp_status;
            out_last_reg   <= 1'b1;
            out_count_reg  <= COUNT_W'(fill_reg);
        end else if (cmd.post_point) begin
            out_x_reg      <= gat_rdata[COORD_W-1:0];
            out_y_reg      <= gat_rdata[POINT_W-1:COORD_W];
            out_has_reg    <= 1'b1;
            out_status_reg <= ST_DONE;
            out_last_reg   <= (emit_idx_reg == gat_cnt_reg);
            out_count_reg  <= COUNT_W'(fill_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_y_reg, out_x_reg};
    assign m_tuser  = {out_status_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

    assign stat.op        = op_reg;
    assign stat.full      = (fill_reg == CNT_W'(CAPACITY));
    assign stat.scan_done = (rd_idx_reg == fill_reg) && !v1_reg && !v2_reg;
    assign stat.gat_zero  = (gat_cnt_reg == '0);
    assign stat.emit_last = (emit_idx_reg == gat_cnt_reg);
    assign stat.out_free  = out_free;

    `WCT_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(CAPACITY), "fill level beyond capacity")
    `WCT_ASSERT_IMP(a_compact_behind, v2_reg, ({1'b0, wr_idx_reg} + {1'b0, gat_cnt_reg}) < {1'b0, rd_idx_reg}, "compaction write overtook read")
    `WCT_ASSERT_IMP(a_post_free, cmd.post_resp || cmd.post_point, !out_valid_reg || m_tready, "result posted over an untaken one")
    `WCT_ASSERT_IMP(a_point_pending, cmd.post_point, gat_cnt_reg != '0 && emit_idx_reg != '0, "point posted with empty gather buffer")

endmodule

### design/waypoint_coverage_table_core.sv
// Waypoint coverage table. Add and clear go from acceptance through an execute state
// to a response state that posts the result once the output is free, then return to idle.
// Remove exact and remove covered scan the stored points in the point RAM one entry
// per cycle (read, square, compare, write back), compacting the kept points in place.
// Remove covered then emits each deleted point with one gather RAM read, waiting for a free output.
// Reset clears the fill level, sequencer and output valid, and loads radius 2560.
module waypoint_coverage_table_core #(
    parameter int CAPACITY = wct_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [wct_pkg::COORD_W-1:0]   cfg_wr_data,   // coverage_radius
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wct_pkg::S_TDATA_W-1:0] s_tdata,       // x_coord[23:0], y_coord[47:24]
    input  logic [wct_pkg::S_TUSER_W-1:0] s_tuser,       // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wct_pkg::M_TDATA_W-1:0] m_tdata,       // x_out[23:0], y_out[47:24],
                                                         // count[54:48], zero[55]
    output logic [wct_pkg::M_TUSER_W-1:0] m_tuser,       // has_point[0], status[2:1]
    output logic                          m_tlast
);
    import wct_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    wct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wct_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
